// ----- rtl/lmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfd_pkg
// Types, command codes and control-word table shared by the LED matrix
// frame driver modules.
// ----------------------------------------------------------------------------
package lmfd_pkg;

  // One input item: a command with its coordinates
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] row;
    logic [2:0] col;
    logic [3:0] width;
    logic [3:0] height;
    logic       pixel_value;
  } in_item_t;

  // One result item: one 12-bit display word plus end-of-burst flag
  typedef struct packed {
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       last_word;
  } out_item_t;

  // Control word: register address and data
  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
  } ctl_word_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Command codes
  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_RECT  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Init burst: control words, then one clear word per display row
  localparam int unsigned NUM_CTL    = 4;
  localparam int unsigned INIT_WORDS = 12;

  // Control words sent at the start of an init burst
  function automatic ctl_word_t ctl_word(input logic [1:0] idx);
    ctl_word_t w;
    unique case (idx)
      2'd0:    w = '{addr: 4'h9, data: 8'h00};
      2'd1:    w = '{addr: 4'hA, data: 8'h0F};
      2'd2:    w = '{addr: 4'hB, data: 8'h07};
      default: w = '{addr: 4'hC, data: 8'h01};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lmfd_row_unit.sv -----
// ----------------------------------------------------------------------------
// lmfd_row_unit
// Shared row update unit: given one frame row and its index, returns the row
// after a pixel write or rectangle outline command. Off-matrix pixels drop out.
// ----------------------------------------------------------------------------
module lmfd_row_unit import lmfd_pkg::*; (
  input  in_item_t   cmd_i,
  input  logic [2:0] y_i,
  input  logic [7:0] row_i,
  output logic [7:0] row_o
);

  logic [5:0] r6;
  logic [5:0] c6;
  logic [5:0] y6;
  logic [5:0] row_end;
  logic [5:0] col_end;
  logic [5:0] row_bot;
  logic [5:0] col_rgt;
  logic       on_edge_row;
  logic       in_span;
  logic [7:0] rect_mask;
  logic [7:0] pix_mask;

  // Edge positions; a wrap below zero lands far above 7 and never matches
  assign r6      = {3'b000, cmd_i.row};
  assign c6      = {3'b000, cmd_i.col};
  assign y6      = {3'b000, y_i};
  assign row_end = r6 + {2'b00, cmd_i.height};
  assign col_end = c6 + {2'b00, cmd_i.width};
  assign row_bot = row_end - 6'd1;
  assign col_rgt = col_end - 6'd1;

  // Top/bottom edges need a nonzero width, sides a nonzero height
  assign on_edge_row = (cmd_i.width != 4'd0) && ((y6 == r6) || (y6 == row_bot));
  assign in_span     = (cmd_i.height != 4'd0) && (y6 >= r6) && (y6 < row_end);

  // Outline mask, column j sits at bit 7-j
  always_comb begin
    rect_mask = '0;
    for (int j = 0; j < 8; j++) begin
      rect_mask[7-j] = (on_edge_row && (6'(j) >= c6) && (6'(j) < col_end)) ||
                       (in_span && ((6'(j) == c6) || (6'(j) == col_rgt)));
    end
  end

  assign pix_mask = 8'h80 >> cmd_i.col;

  // Apply the command to this row
  always_comb begin
    unique case (cmd_i.func)
      FUNC_PIXEL: begin
        if (y_i == cmd_i.row) begin
          row_o = cmd_i.pixel_value ? (row_i | pix_mask) : (row_i & ~pix_mask);
        end else begin
          row_o = row_i;
        end
      end
      FUNC_RECT: row_o = row_i | rect_mask;
      default:   row_o = row_i;
    endcase
  end

endmodule

// ----- rtl/led_matrix_frame_driver.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_driver
// 8x8 one-bit frame buffer with pixel, rectangle and init commands; each
// command produces a burst of 12-bit display words.
// ----------------------------------------------------------------------------
// The item is latched as the sequencer enters ST_RUN; each word is then built
// and registered. A pixel or rectangle item yields NUM_ROWS words, an init item
// INIT_WORDS, an unused code none; no new item is taken until a burst ends. The
// single row update unit handles one row (one word) per cycle when output is free.
// Reset clears the frame buffer, the sequencer and the output valid.
module led_matrix_frame_driver import lmfd_pkg::*; #(
  parameter int NUM_ROWS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int         RIW             = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam logic [3:0] LAST_FRAME_STEP = 4'(NUM_ROWS - 1);
  localparam logic [3:0] LAST_INIT_STEP  = 4'(INIT_WORDS - 1);
  localparam logic [3:0] CTL_STEPS       = 4'(NUM_CTL);

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  in_item_t   cmd_r;
  logic [7:0] frame_r [NUM_ROWS];
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic           accept;
  logic           out_free;
  logic           advance;
  logic           is_init;
  logic [RIW-1:0] row_idx;
  logic [7:0]     row_old;
  logic [7:0]     row_new;
  ctl_word_t      ctl;
  out_item_t      word;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = (state_r == ST_RUN) && out_free;
  assign is_init  = (cmd_r.func == FUNC_INIT);

  // Row read for the current step
  assign row_idx = step_r[RIW-1:0];
  assign row_old = is_init ? 8'h00 : frame_r[row_idx];

  lmfd_row_unit u_row (
    .cmd_i (cmd_r),
    .y_i   (3'(step_r)),
    .row_i (row_old),
    .row_o (row_new)
  );

  // Word for the current step
  assign ctl = ctl_word(step_r[1:0]);

  always_comb begin
    if (is_init) begin
      if (step_r < CTL_STEPS) begin
        word.reg_address = ctl.addr;
        word.reg_data    = ctl.data;
      end else begin
        word.reg_address = step_r - CTL_STEPS + 4'd1;
        word.reg_data    = 8'h00;
      end
      word.last_word = (step_r == LAST_INIT_STEP);
    end else begin
      word.reg_address = step_r + 4'd1;
      word.reg_data    = row_new;
      word.last_word   = (step_r == LAST_FRAME_STEP);
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.func != FUNC_NONE)) begin
          state_nxt = ST_RUN;
          step_nxt  = 4'd0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (word.last_word) begin
            state_nxt = ST_IDLE;
            step_nxt  = 4'd0;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = 4'd0;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 4'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
  end

  // Frame buffer write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        frame_r[i] <= 8'h00;
      end
    end else if (advance && !is_init) begin
      frame_r[row_idx] <= row_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.func != FUNC_NONE)) |=> (state_r == ST_RUN))
    else $error("valid command did not start a burst");

  a_unused_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.func == FUNC_NONE)) |=> (state_r == ST_IDLE) && !$rose(out_valid_r))
    else $error("unused command produced activity");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && word.last_word) |=> (state_r == ST_IDLE) && out_item_r.last_word)
    else $error("burst did not end on last word");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= LAST_INIT_STEP))
    else $error("step counter out of range");

  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (step_r == 4'd0))
    else $error("step counter not cleared in idle");

endmodule
